### sv/cda_pkg.sv
// shared types, constants and month table for the calendar date advance block
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

  // calendar constants
  localparam logic [15:0] YearDefault   = 16'd2000;
  localparam logic [3:0]  MonthsPerYear = 4'd12;
  localparam logic [15:0] YearMax       = 16'hFFFF;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DAYS = 4'b0010,
    ST_MONS = 4'b0100,
    ST_YEAR = 4'b1000
  } state_e;

  // normalized starting date
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [15:0] year;
  } norm_t;

  // month length without leap years, 31 for codes outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### sv/cda_req_if.sv
// request channel carrying a date and an offset
`timescale 1ns / 1ps
`default_nettype none

interface cda_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  in_day;
  logic [7:0]  in_month;
  logic [15:0] in_year;
  logic [15:0] add_days;
  logic [11:0] add_months;
  logic [11:0] add_years;

  modport src (
    output valid, in_day, in_month, in_year, add_days, add_months, add_years,
    input  ready
  );
  modport sink (
    input  valid, in_day, in_month, in_year, add_days, add_months, add_years,
    output ready
  );
endinterface

`default_nettype wire

### sv/cda_rsp_if.sv
// response channel carrying the advanced date
`timescale 1ns / 1ps
`default_nettype none

interface cda_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [15:0] out_year;
  logic        year_overflow;

  modport src (
    output valid, out_day, out_month, out_year, year_overflow,
    input  ready
  );
  modport sink (
    input  valid, out_day, out_month, out_year, year_overflow,
    output ready
  );
endinterface

`default_nettype wire

### sv/cda_norm.sv
// normalization of the incoming date: month clamp, day clamp, default year
`timescale 1ns / 1ps
`default_nettype none

module cda_norm
  import cda_pkg::*;
(
  input  logic [7:0]  day_i,
  input  logic [7:0]  month_i,
  input  logic [15:0] year_i,
  output norm_t       norm_o
);

  logic [3:0] mon;
  logic [4:0] len;

  // month into 1..12
  always_comb begin
    if (month_i == 8'd0) begin
      mon = 4'd1;
    end else if (month_i > {4'd0, MonthsPerYear}) begin
      mon = MonthsPerYear;
    end else begin
      mon = month_i[3:0];
    end
  end

  assign len = month_len(mon);

  // day into 1..length of the clamped month, zero year replaced
  always_comb begin
    norm_o.mon = mon;
    if (day_i == 8'd0) begin
      norm_o.day = 5'd1;
    end else if (day_i > {3'd0, len}) begin
      norm_o.day = len;
    end else begin
      norm_o.day = day_i[4:0];
    end
    norm_o.year = (year_i == 16'd0) ? YearDefault : year_i;
  end

endmodule

`default_nettype wire

### sv/calendar_date_advance.sv
// top level: date advance by days, months and years over a shared subtractor
//
//   channel  dir  modport  payload
//   req_i    in   sink     in_day, in_month, in_year, add_days, add_months, add_years
//   rsp_o    out  src      out_day, out_month, out_year, year_overflow
//
// a request is accepted, then the day loop retires one month length per cycle through
// the single subtractor, which then folds the months into years, 12 months per cycle,
// and a final year step adds the year offset.
// reset clears the sequencer and the output valid; nothing needs a clearing pass.
// a held response does not block the next request; the final step waits for the
// output register to free up.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_advance
  import cda_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  cda_req_if.sink   req_i,
  cda_rsp_if.src    rsp_o
);

  state_e      state_q, state_d;
  logic [16:0] day_q, day_d;
  logic [3:0]  mon_q, mon_d;
  logic [16:0] year_q, year_d;
  logic [12:0] mcnt_q, mcnt_d;
  logic [11:0] addm_q, addm_d;
  logic [11:0] addy_q, addy_d;
  logic        out_valid_q, out_valid_d;
  logic [4:0]  out_day_q, out_day_d;
  logic [3:0]  out_month_q, out_month_d;
  logic [15:0] out_year_q, out_year_d;
  logic        out_ovf_q, out_ovf_d;

  norm_t       norm;
  logic [4:0]  cur_len;
  logic [16:0] sub_a, sub_b;
  logic [17:0] sub_diff;
  logic        sub_borrow;
  logic [16:0] year_sum;

  // input normalization
  cda_norm u_norm (
    .day_i   (req_i.in_day),
    .month_i (req_i.in_month),
    .year_i  (req_i.in_year),
    .norm_o  (norm)
  );

  assign cur_len = month_len(mon_q);

  // shared subtractor: month length in the day loop, a year of months after
  always_comb begin
    if (state_q == ST_DAYS) begin
      sub_a = day_q;
      sub_b = {12'd0, cur_len};
    end else begin
      sub_a = {4'd0, mcnt_q};
      sub_b = {13'd0, MonthsPerYear};
    end
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[17];
  assign year_sum   = year_q + {5'd0, addy_q};

  // handshake
  assign req_i.ready         = (state_q == ST_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.out_day       = out_day_q;
  assign rsp_o.out_month     = out_month_q;
  assign rsp_o.out_year      = out_year_q;
  assign rsp_o.year_overflow = out_ovf_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    day_d       = day_q;
    mon_d       = mon_q;
    year_d      = year_q;
    mcnt_d      = mcnt_q;
    addm_d      = addm_q;
    addy_d      = addy_q;
    out_valid_d = out_valid_q & ~rsp_o.ready;
    out_day_d   = out_day_q;
    out_month_d = out_month_q;
    out_year_d  = out_year_q;
    out_ovf_d   = out_ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          day_d   = {12'd0, norm.day} + {1'b0, req_i.add_days};
          mon_d   = norm.mon;
          year_d  = {1'b0, norm.year};
          addm_d  = req_i.add_months;
          addy_d  = req_i.add_years;
          state_d = ST_DAYS;
        end
      end
      ST_DAYS: begin
        // day beyond month length: retire the month
        if (!sub_borrow && (sub_diff[16:0] != 17'd0)) begin
          day_d = sub_diff[16:0];
          if (mon_q == MonthsPerYear) begin
            mon_d  = 4'd1;
            year_d = year_q + 17'd1;
          end else begin
            mon_d = mon_q + 4'd1;
          end
        end else begin
          mcnt_d  = {9'd0, mon_q} + {1'b0, addm_q} - 13'd1;
          state_d = ST_MONS;
        end
      end
      ST_MONS: begin
        // zero-based month count folded into years
        if (!sub_borrow) begin
          mcnt_d = sub_diff[12:0];
          year_d = year_q + 17'd1;
        end else begin
          mon_d   = mcnt_q[3:0] + 4'd1;
          state_d = ST_YEAR;
        end
      end
      ST_YEAR: begin
        // year offset, saturate, load output when free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_day_d   = day_q[4:0];
          out_month_d = mon_q;
          if (year_sum[16]) begin
            out_year_d = YearMax;
            out_ovf_d  = 1'b1;
          end else begin
            out_year_d = year_sum[15:0];
            out_ovf_d  = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    day_q       <= day_d;
    mon_q       <= mon_d;
    year_q      <= year_d;
    mcnt_q      <= mcnt_d;
    addm_q      <= addm_d;
    addy_q      <= addy_d;
    out_day_q   <= out_day_d;
    out_month_q <= out_month_d;
    out_year_q  <= out_year_d;
    out_ovf_q   <= out_ovf_d;
  end

endmodule

`default_nettype wire

### verif/calendar_date_advance_tb.sv
// testbench for the calendar date advance block: directed and random dates and offsets checked against a predictor
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_advance_tb;
  import cda_pkg::*;

  // one request as driven on the request channel
  typedef struct packed {
    logic [7:0]  day;
    logic [7:0]  month;
    logic [15:0] year;
    logic [15:0] add_days;
    logic [11:0] add_months;
    logic [11:0] add_years;
  } date_req_t;

  // one advanced date as seen on the response channel
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        year_overflow;
  } date_rsp_t;

  // month lengths of a year without leap days
  localparam int unsigned MonthDays [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // day offsets above this count as long day rollovers in the summary
  localparam int unsigned LongDayOffset = 3000;

  // directed requests: clamps, year zero, rollovers, extremes and overflow
  localparam int NumDirected = 21;
  localparam date_req_t DirectedReqs [NumDirected] = '{
    '{8'd1,   8'd1,   16'd2023,  16'd0,     12'd0,    12'd0},
    '{8'd0,   8'd0,   16'd0,     16'd0,     12'd0,    12'd0},
    '{8'd255, 8'd255, 16'd65535, 16'd0,     12'd0,    12'd0},
    '{8'd31,  8'd2,   16'd2001,  16'd0,     12'd0,    12'd0},
    '{8'd31,  8'd4,   16'd2001,  16'd0,     12'd0,    12'd0},
    '{8'd31,  8'd13,  16'd1999,  16'd0,     12'd0,    12'd0},
    '{8'd31,  8'd12,  16'd1999,  16'd1,     12'd0,    12'd0},
    '{8'd28,  8'd2,   16'd2001,  16'd1,     12'd0,    12'd0},
    '{8'd31,  8'd1,   16'd2020,  16'd0,     12'd1,    12'd0},
    '{8'd1,   8'd1,   16'd1,     16'd65535, 12'd0,    12'd0},
    '{8'd255, 8'd255, 16'd65535, 16'd65535, 12'd4095, 12'd4095},
    '{8'd1,   8'd1,   16'd65535, 16'd0,     12'd0,    12'd1},
    '{8'd1,   8'd1,   16'd65534, 16'd0,     12'd12,   12'd0},
    '{8'd15,  8'd6,   16'd0,     16'd0,     12'd4095, 12'd0},
    '{8'd10,  8'd3,   16'd2024,  16'd0,     12'd0,    12'd4095},
    '{8'd31,  8'd12,  16'd65535, 16'd1,     12'd0,    12'd0},
    '{8'd1,   8'd11,  16'd2000,  16'd61,    12'd0,    12'd0},
    '{8'd0,   8'd2,   16'd0,     16'd365,   12'd0,    12'd0},
    '{8'd170, 8'd85,  16'd43690, 16'd21845, 12'd2730, 12'd1365},
    '{8'd85,  8'd170, 16'd21845, 16'd43690, 12'd1365, 12'd2730},
    '{8'd30,  8'd9,   16'd61439, 16'd0,     12'd4095, 12'd4095}
  };

  localparam int NumRandom = 250;

  // scoreboard: predicts each advanced date and checks responses in order
  class date_scoreboard;
    date_rsp_t   expected_dates[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned checked;
    int unsigned overflows;
    int unsigned long_rolls;

    function new();
      errors     = 0;
      requests   = 0;
      checked    = 0;
      overflows  = 0;
      long_rolls = 0;
    endfunction

    function int unsigned pending();
      return expected_dates.size();
    endfunction

    // normalize the start date, then add days, months and years
    function date_rsp_t advance_date(date_req_t r);
      int unsigned day;
      int unsigned mon;
      int unsigned year;
      date_rsp_t   res;
      mon = r.month;
      if (mon < 1) mon = 1;
      if (mon > MonthsPerYear) mon = MonthsPerYear;
      day = r.day;
      if (day < 1) day = 1;
      if (day > MonthDays[mon]) day = MonthDays[mon];
      year = r.year;
      if (year == 0) year = YearDefault;
      // day rollover through the month table
      day += r.add_days;
      while (day > MonthDays[mon]) begin
        day -= MonthDays[mon];
        mon++;
        if (mon > MonthsPerYear) begin
          year++;
          mon -= MonthsPerYear;
        end
      end
      // month offset does not re-clamp the day
      mon += r.add_months;
      year += (mon - 1) / MonthsPerYear;
      mon = (mon - 1) % MonthsPerYear + 1;
      year += r.add_years;
      res.year_overflow = (year > YearMax);
      if (res.year_overflow) year = YearMax;
      res.day   = day[4:0];
      res.month = mon[3:0];
      res.year  = year[15:0];
      return res;
    endfunction

    function void note_request(date_req_t r);
      date_rsp_t exp_date;
      exp_date = advance_date(r);
      expected_dates.push_back(exp_date);
      requests++;
      if (exp_date.year_overflow) overflows++;
      if (r.add_days > LongDayOffset) long_rolls++;
    endfunction

    function void check_result(date_rsp_t got);
      date_rsp_t exp_date;
      if (expected_dates.size() == 0) begin
        $error("response with no request outstanding: %0d/%0d/%0d ovf %0b",
               got.day, got.month, got.year, got.year_overflow);
        errors++;
        return;
      end
      exp_date = expected_dates.pop_front();
      checked++;
      if (got.day !== exp_date.day) begin
        $error("out_day: expected %0d, got %0d", exp_date.day, got.day);
        errors++;
      end
      if (got.month !== exp_date.month) begin
        $error("out_month: expected %0d, got %0d", exp_date.month, got.month);
        errors++;
      end
      if (got.year !== exp_date.year) begin
        $error("out_year: expected %0d, got %0d", exp_date.year, got.year);
        errors++;
      end
      if (got.year_overflow !== exp_date.year_overflow) begin
        $error("year_overflow: expected %0b, got %0b", exp_date.year_overflow,
               got.year_overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  cda_req_if req_if ();
  cda_rsp_if rsp_if ();

  calendar_date_advance dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.src)
  );

  date_scoreboard board = new();

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // note every accepted request
  always @(posedge clk_i) begin
    if (req_if.valid && req_if.ready) begin
      board.note_request('{req_if.in_day, req_if.in_month, req_if.in_year,
                           req_if.add_days, req_if.add_months, req_if.add_years});
    end
  end

  // check every accepted response
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      board.check_result('{rsp_if.out_day, rsp_if.out_month, rsp_if.out_year,
                           rsp_if.year_overflow});
    end
  end

  // receiver stalls: a fresh 32-bit ready pattern each window
  logic [31:0] ready_pattern = '1;
  logic [4:0]  ready_phase   = '0;

  always @(posedge clk_i) begin
    if (ready_phase == 5'd0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = '1;
        1:       ready_pattern = $urandom;
        2:       ready_pattern = $urandom & $urandom;
        default: ready_pattern = {8'hFF, 24'h0};
      endcase
    end
    rsp_if.ready <= ready_pattern[ready_phase];
    ready_phase  <= ready_phase + 5'd1;
  end

  int unsigned burst_left = 0;

  // present one request and hold it until accepted
  task automatic send_req(input date_req_t r);
    req_if.valid      <= 1'b1;
    req_if.in_day     <= r.day;
    req_if.in_month   <= r.month;
    req_if.in_year    <= r.year;
    req_if.add_days   <= r.add_days;
    req_if.add_months <= r.add_months;
    req_if.add_years  <= r.add_years;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // sender bursts with random gaps between them
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    req_if.valid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // hold off until every outstanding date has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() > 0);
  endtask

  // mostly plausible dates with short offsets, some noise and long offsets
  function automatic date_req_t random_req();
    date_req_t   r;
    int unsigned pick;
    if ($urandom_range(0, 9) < 8) begin
      r.day   = 8'($urandom_range(1, 31));
      r.month = 8'($urandom_range(1, 12));
      pick = $urandom_range(0, 9);
      if (pick < 5)       r.year = 16'($urandom_range(1900, 2100));
      else if (pick == 5) r.year = '0;
      else                r.year = 16'($urandom_range(0, 65535));
    end else begin
      r.day   = 8'($urandom_range(0, 255));
      r.month = 8'($urandom_range(0, 255));
      r.year  = 16'($urandom_range(0, 65535));
    end
    pick = $urandom_range(0, 99);
    if (pick < 80)      r.add_days = 16'($urandom_range(0, 400));
    else if (pick < 92) r.add_days = 16'($urandom_range(0, 3000));
    else                r.add_days = 16'($urandom_range(0, 65535));
    r.add_months = ($urandom_range(0, 9) < 6) ? 12'($urandom_range(0, 24))
                                              : 12'($urandom_range(0, 4095));
    r.add_years  = ($urandom_range(0, 9) < 6) ? 12'($urandom_range(0, 50))
                                              : 12'($urandom_range(0, 4095));
    return r;
  endfunction

  // stimulus and end of run
  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.in_day     = '0;
    req_if.in_month   = '0;
    req_if.in_year    = '0;
    req_if.add_days   = '0;
    req_if.add_months = '0;
    req_if.add_years  = '0;
    rsp_if.ready      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedReqs[i]) begin
      send_req(DirectedReqs[i]);
      pace_sender();
    end
    drain_results();

    for (int n = 0; n < NumRandom; n++) begin
      send_req(random_req());
      if (n % 80 == 79) drain_results();
      else              pace_sender();
    end

    // wait out the last results, then watch for strays
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() > 0);
    repeat (50) @(posedge clk_i);

    $display("checked %0d advanced dates from %0d requests", board.checked, board.requests);
    $display("%0d year overflows, %0d long day rollovers", board.overflows, board.long_rolls);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
